// File: design/ezr_pkg.sv
// Shared constants and types for the ZYX Euler rotation matrix core.
package ezr_pkg;

  localparam int ANGLE_W           = 16;
  localparam int ENTRY_W           = 16;
  localparam int OUT_FRAC_BITS_DEF = 14;

  // Angle units: 1/64 degree.
  localparam int UNITS_TURN    = 23040;
  localparam int UNITS_QUARTER = 5760;
  localparam int UNITS_EIGHTH  = 2880;

  // pi/11520 in Q40.
  localparam logic [28:0] RAD_K40 = 29'd299845282;
  localparam int          ONE_Q30 = 1 << 30;

  // Series depth and pipeline bookkeeping.
  localparam int N_COS_TERMS = 7;
  localparam int N_SIN_TERMS = 6;
  localparam int TERM_LAT    = 3;
  localparam int SC_LAT      = 4 + TERM_LAT * N_COS_TERMS + 1;
  localparam int MX_LAT      = 6;
  localparam int CORE_LAT    = SC_LAT + MX_LAT;

  typedef logic signed [31:0]        trig_t;   // Q30, range [-2^30, 2^30]
  typedef logic signed [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sc_t;

  typedef struct packed {
    entry_t r00;
    entry_t r01;
    entry_t r02;
    entry_t r10;
    entry_t r11;
    entry_t r12;
    entry_t r20;
    entry_t r21;
    entry_t r22;
  } mat_t;

endpackage

// File: design/ezr_term.sv
// One Taylor series term: t' = floor(floor(t*x2/2^30)/DIV), accumulate +/- t'.
module ezr_term
  import ezr_pkg::*;
#(
  parameter int unsigned DIV = 2,
  parameter bit          SUB = 1'b1
) (
  input  logic               clk,
  input  logic               en,
  input  logic [30:0]        t_in,
  input  logic [29:0]        x2_in,
  input  logic signed [31:0] acc_in,
  output logic [30:0]        t_out,
  output logic signed [31:0] acc_out
);

  // floor(2^32/DIV): quotient estimate is low by at most one
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);
  localparam logic [7:0]  DIV_C = 8'(DIV);

  logic [60:0]        p_r;
  logic signed [31:0] acc_a_r;
  logic [29:0]        n_r;
  logic [61:0]        pr_r;
  logic signed [31:0] acc_b_r;
  logic [30:0]        t_r;
  logic signed [31:0] acc_r;

  logic [60:0]        p_nxt;
  logic [29:0]        n_nxt;
  logic [61:0]        pr_nxt;
  logic [29:0]        q0;
  logic [29:0]        rem;
  logic [29:0]        q;
  logic signed [31:0] acc_nxt;

  assign p_nxt  = 61'(t_in) * 61'(x2_in);
  assign n_nxt  = p_r[59:30];
  assign pr_nxt = 62'(n_nxt) * 62'(RECIP);

  always_comb begin
    q0  = pr_r[61:32];
    rem = n_r - 30'(q0 * 30'(DIV_C));
    q   = (rem >= 30'(DIV_C)) ? q0 + 30'd1 : q0;
    if (SUB) begin
      acc_nxt = acc_b_r - $signed({2'b00, q});
    end else begin
      acc_nxt = acc_b_r + $signed({2'b00, q});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= p_nxt;
      acc_a_r <= acc_in;
      n_r     <= n_nxt;
      pr_r    <= pr_nxt;
      acc_b_r <= acc_a_r;
      t_r     <= {1'b0, q};
      acc_r   <= acc_nxt;
    end
  end

  assign t_out   = t_r;
  assign acc_out = acc_r;

endmodule

// File: design/ezr_sincos.sv
// Sine and cosine in Q30 of one angle: fold to an octant, then series pipeline.
module ezr_sincos
  import ezr_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [ANGLE_W-1:0] angle,
  output sc_t                       sc
);

  localparam logic signed [16:0] TURN_S     = 17'(UNITS_TURN);
  localparam logic signed [16:0] TWO_TURN_S = 17'(2 * UNITS_TURN);
  localparam logic [14:0]        Q1_C       = 15'(UNITS_QUARTER);
  localparam logic [14:0]        Q2_C       = 15'(2 * UNITS_QUARTER);
  localparam logic [14:0]        Q3_C       = 15'(3 * UNITS_QUARTER);
  localparam logic [12:0]        QUART_C    = 13'(UNITS_QUARTER);
  localparam logic [12:0]        EIGHTH_C   = 13'(UNITS_EIGHTH);
  localparam logic [30:0]        ONE_T      = 31'(ONE_Q30);
  localparam logic signed [31:0] ONE_S      = 32'(ONE_Q30);
  localparam int                 X2_TAPS    = TERM_LAT * (N_COS_TERMS - 1);
  localparam int                 QS_DEPTH   = TERM_LAT * N_COS_TERMS;

  // stage 1: wrap into one turn
  logic signed [16:0] v17;
  logic signed [16:0] a17;
  logic [14:0]        a_r;

  always_comb begin
    v17 = {angle[ANGLE_W-1], angle};
    if (v17 < -TURN_S) begin
      a17 = v17 + TWO_TURN_S;
    end else if (v17 < 17'sd0) begin
      a17 = v17 + TURN_S;
    end else if (v17 >= TURN_S) begin
      a17 = v17 - TURN_S;
    end else begin
      a17 = v17;
    end
  end

  // stage 2: quadrant and octant fold
  logic [1:0]  q_nxt;
  logic [14:0] base;
  logic [12:0] r13;
  logic        swp_nxt;
  logic [11:0] b_nxt;
  logic [1:0]  q2_r;
  logic        swp2_r;
  logic [11:0] b_r;

  always_comb begin
    if (a_r >= Q3_C) begin
      q_nxt = 2'd3;
      base  = Q3_C;
    end else if (a_r >= Q2_C) begin
      q_nxt = 2'd2;
      base  = Q2_C;
    end else if (a_r >= Q1_C) begin
      q_nxt = 2'd1;
      base  = Q1_C;
    end else begin
      q_nxt = 2'd0;
      base  = '0;
    end
    r13     = 13'(a_r - base);
    swp_nxt = r13 > EIGHTH_C;
    b_nxt   = swp_nxt ? 12'(QUART_C - r13) : r13[11:0];
  end

  // stage 3: to radians, Q30
  logic [40:0] xk;
  logic [40:0] xk_rnd;
  logic [29:0] x_r;
  logic [1:0]  q3_r;
  logic        swp3_r;

  assign xk     = 41'(b_r) * 41'(RAD_K40);
  assign xk_rnd = xk + 41'd512;

  // stage 4: x squared
  logic [59:0] xx;
  logic [29:0] x2_r;
  logic [29:0] x4_r;
  logic [1:0]  q4_r;
  logic        swp4_r;

  assign xx = 60'(x_r) * 60'(x_r);

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a17[14:0];
      q2_r   <= q_nxt;
      swp2_r <= swp_nxt;
      b_r    <= b_nxt;
      x_r    <= xk_rnd[39:10];
      q3_r   <= q2_r;
      swp3_r <= swp2_r;
      x2_r   <= xx[59:30];
      x4_r   <= x_r;
      q4_r   <= q3_r;
      swp4_r <= swp3_r;
    end
  end

  // x2 and quadrant info ride alongside the term pipeline
  logic [29:0] x2_sh_r [X2_TAPS];
  logic [2:0]  qs_sh_r [QS_DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      x2_sh_r[0] <= x2_r;
      for (int i = 1; i < X2_TAPS; i++) begin
        x2_sh_r[i] <= x2_sh_r[i-1];
      end
      qs_sh_r[0] <= {q4_r, swp4_r};
      for (int i = 1; i < QS_DEPTH; i++) begin
        qs_sh_r[i] <= qs_sh_r[i-1];
      end
    end
  end

  logic [30:0]        cos_t   [N_COS_TERMS+1];
  logic signed [31:0] cos_acc [N_COS_TERMS+1];
  logic [30:0]        sin_t   [N_SIN_TERMS+1];
  logic signed [31:0] sin_acc [N_SIN_TERMS+1];
  logic [29:0]        x2_tap  [N_COS_TERMS];

  assign cos_t[0]   = ONE_T;
  assign cos_acc[0] = ONE_S;
  assign sin_t[0]   = {1'b0, x4_r};
  assign sin_acc[0] = $signed({2'b00, x4_r});
  assign x2_tap[0]  = x2_r;

  for (genvar k = 1; k < N_COS_TERMS; k++) begin : g_tap
    assign x2_tap[k] = x2_sh_r[TERM_LAT*k-1];
  end

  for (genvar k = 1; k <= N_COS_TERMS; k++) begin : g_cos
    ezr_term #(
      .DIV ((2*k-1) * (2*k)),
      .SUB ((k % 2) == 1)
    ) u_term (
      .clk     (clk),
      .en      (en),
      .t_in    (cos_t[k-1]),
      .x2_in   (x2_tap[k-1]),
      .acc_in  (cos_acc[k-1]),
      .t_out   (cos_t[k]),
      .acc_out (cos_acc[k])
    );
  end

  for (genvar k = 1; k <= N_SIN_TERMS; k++) begin : g_sin
    ezr_term #(
      .DIV ((2*k) * (2*k+1)),
      .SUB ((k % 2) == 1)
    ) u_term (
      .clk     (clk),
      .en      (en),
      .t_in    (sin_t[k-1]),
      .x2_in   (x2_tap[k-1]),
      .acc_in  (sin_acc[k-1]),
      .t_out   (sin_t[k]),
      .acc_out (sin_acc[k])
    );
  end

  // sine series is one term shorter: pad to line up with cosine
  logic signed [31:0] sin_dly_r [TERM_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sin_dly_r[0] <= sin_acc[N_SIN_TERMS];
      for (int i = 1; i < TERM_LAT; i++) begin
        sin_dly_r[i] <= sin_dly_r[i-1];
      end
    end
  end

  // output stage: clamp, undo octant swap, apply quadrant
  logic signed [31:0] s_cl;
  logic signed [31:0] c_cl;
  logic signed [31:0] s0;
  logic signed [31:0] c0;
  logic [2:0]         qs;
  sc_t                sc_nxt;
  sc_t                sc_r;

  function automatic logic signed [31:0] clamp_q30(input logic signed [31:0] v);
    if (v < 32'sd0) begin
      return 32'sd0;
    end else if (v > ONE_S) begin
      return ONE_S;
    end else begin
      return v;
    end
  endfunction

  always_comb begin
    qs   = qs_sh_r[QS_DEPTH-1];
    s_cl = clamp_q30(sin_dly_r[TERM_LAT-1]);
    c_cl = clamp_q30(cos_acc[N_COS_TERMS]);
    s0   = qs[0] ? c_cl : s_cl;
    c0   = qs[0] ? s_cl : c_cl;
    case (qs[2:1])
      2'd0: begin
        sc_nxt.s = s0;
        sc_nxt.c = c0;
      end
      2'd1: begin
        sc_nxt.s = c0;
        sc_nxt.c = -s0;
      end
      2'd2: begin
        sc_nxt.s = -s0;
        sc_nxt.c = -c0;
      end
      default: begin
        sc_nxt.s = -c0;
        sc_nxt.c = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r <= sc_nxt;
    end
  end

  assign sc = sc_r;

endmodule

// File: design/ezr_matrix.sv
// Forms R = Rz*Ry*Rx from the three sine/cosine pairs and rounds each entry.
module ezr_matrix
  import ezr_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic en,
  input  sc_t  scx,
  input  sc_t  scy,
  input  sc_t  scz,
  output mat_t mat
);

  localparam int RW  = OUT_FRAC_BITS + 3;
  localparam int SH  = 60 - OUT_FRAC_BITS;
  localparam int LIM = 1 << OUT_FRAC_BITS;
  localparam int HI  = (LIM > 32767) ? 32767 : LIM;
  localparam int LO  = (-LIM < -32768) ? -32768 : -LIM;
  localparam logic signed [63:0]   HALF_SH = 64'sd1 <<< (SH - 1);
  localparam logic signed [63:0]   HALF_30 = 64'sd1 <<< 29;
  localparam logic signed [RW-1:0] HI_C    = RW'(HI);
  localparam logic signed [RW-1:0] LO_C    = RW'(LO);

  // M1: first products
  logic signed [63:0] czsy_p_r, szsy_p_r;
  logic signed [63:0] czcy1_r, szcy1_r, cysx1_r, cycx1_r;
  trig_t sx1_r, cx1_r, sz1_r, cz1_r, sy1_r;

  // M2: rounded cz*sy, sz*sy
  logic signed [63:0] czsy_t, szsy_t;
  trig_t czsy_r, szsy_r;
  logic signed [63:0] czcy2_r, szcy2_r, cysx2_r, cycx2_r;
  trig_t sx2_r, cx2_r, sz2_r, cz2_r, sy2_r;

  assign czsy_t = czsy_p_r + HALF_30 - 64'(czsy_p_r[63]);
  assign szsy_t = szsy_p_r + HALF_30 - 64'(szsy_p_r[63]);

  // M3: second products
  logic signed [63:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic signed [63:0] czcy3_r, szcy3_r, cysx3_r, cycx3_r;
  trig_t sy3_r;

  // M4: Q60 sums, M5: rounded, M6: clamped
  logic signed [63:0]   q60_r [9];
  logic signed [63:0]   q60_nxt [9];
  logic signed [63:0]   rt [9];
  logic signed [RW-1:0] rnd_r [9];
  entry_t               ent_nxt [9];
  entry_t               ent_r [9];

  always_comb begin
    q60_nxt[0] = czcy3_r;
    q60_nxt[1] = a_r - b_r;
    q60_nxt[2] = c_r + d_r;
    q60_nxt[3] = szcy3_r;
    q60_nxt[4] = e_r + f_r;
    q60_nxt[5] = g_r - h_r;
    q60_nxt[6] = -(64'(sy3_r) <<< 30);
    q60_nxt[7] = cysx3_r;
    q60_nxt[8] = cycx3_r;
    for (int i = 0; i < 9; i++) begin
      rt[i] = q60_r[i] + HALF_SH - 64'(q60_r[i][63]);
      if (rnd_r[i] > HI_C) begin
        ent_nxt[i] = ENTRY_W'(HI_C);
      end else if (rnd_r[i] < LO_C) begin
        ent_nxt[i] = ENTRY_W'(LO_C);
      end else begin
        ent_nxt[i] = ENTRY_W'(rnd_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      czsy_p_r <= 64'(scz.c) * 64'(scy.s);
      szsy_p_r <= 64'(scz.s) * 64'(scy.s);
      czcy1_r  <= 64'(scz.c) * 64'(scy.c);
      szcy1_r  <= 64'(scz.s) * 64'(scy.c);
      cysx1_r  <= 64'(scy.c) * 64'(scx.s);
      cycx1_r  <= 64'(scy.c) * 64'(scx.c);
      sx1_r    <= scx.s;
      cx1_r    <= scx.c;
      sz1_r    <= scz.s;
      cz1_r    <= scz.c;
      sy1_r    <= scy.s;

      czsy_r   <= 32'(czsy_t >>> 30);
      szsy_r   <= 32'(szsy_t >>> 30);
      czcy2_r  <= czcy1_r;
      szcy2_r  <= szcy1_r;
      cysx2_r  <= cysx1_r;
      cycx2_r  <= cycx1_r;
      sx2_r    <= sx1_r;
      cx2_r    <= cx1_r;
      sz2_r    <= sz1_r;
      cz2_r    <= cz1_r;
      sy2_r    <= sy1_r;

      a_r      <= 64'(czsy_r) * 64'(sx2_r);
      b_r      <= 64'(sz2_r) * 64'(cx2_r);
      c_r      <= 64'(czsy_r) * 64'(cx2_r);
      d_r      <= 64'(sz2_r) * 64'(sx2_r);
      e_r      <= 64'(szsy_r) * 64'(sx2_r);
      f_r      <= 64'(cz2_r) * 64'(cx2_r);
      g_r      <= 64'(szsy_r) * 64'(cx2_r);
      h_r      <= 64'(cz2_r) * 64'(sx2_r);
      czcy3_r  <= czcy2_r;
      szcy3_r  <= szcy2_r;
      cysx3_r  <= cysx2_r;
      cycx3_r  <= cycx2_r;
      sy3_r    <= sy2_r;

      for (int i = 0; i < 9; i++) begin
        q60_r[i] <= q60_nxt[i];
        rnd_r[i] <= RW'(rt[i] >>> SH);
        ent_r[i] <= ent_nxt[i];
      end
    end
  end

  assign mat.r00 = ent_r[0];
  assign mat.r01 = ent_r[1];
  assign mat.r02 = ent_r[2];
  assign mat.r10 = ent_r[3];
  assign mat.r11 = ent_r[4];
  assign mat.r12 = ent_r[5];
  assign mat.r20 = ent_r[6];
  assign mat.r21 = ent_r[7];
  assign mat.r22 = ent_r[8];

endmodule

// File: design/euler_zyx_rotation_matrix_core.sv
// Top level: ZYX Euler angles (1/64 degree) to a 3x3 rotation matrix (Q1.14).
// An accepted input word passes 32 pipeline stages (most of them the 7-term
//   cosine series, 3 stages per term) and then the output register to reach
//   out_valid. Throughput: one word per cycle while in_stall is low.
// A stall at the output fills one skid word before in_stall rises.
// Reset (rst_n low, synchronous) clears all valid bits; no data is reset.
module euler_zyx_rotation_matrix_core
  import ezr_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ANGLE_W-1:0] in_angle_x,
  input  logic signed [ANGLE_W-1:0] in_angle_y,
  input  logic signed [ANGLE_W-1:0] in_angle_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output entry_t                    out_r00,
  output entry_t                    out_r01,
  output entry_t                    out_r02,
  output entry_t                    out_r10,
  output entry_t                    out_r11,
  output entry_t                    out_r12,
  output entry_t                    out_r20,
  output entry_t                    out_r21,
  output entry_t                    out_r22
);

  // The whole pipe advances together; it only halts when the skid
  // word is occupied, i.e. the output has been stalled with one word waiting
  // and a second one arrived.
  logic en;
  logic skid_v_r;
  logic out_v_r;
  logic [CORE_LAT-1:0] v_r;   // valid bit per pipeline stage

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // Three angle units run side by side, each 26 stages deep.
  sc_t scx, scy, scz;

  ezr_sincos u_sc_x (.clk(clk), .en(en), .angle(in_angle_x), .sc(scx));
  ezr_sincos u_sc_y (.clk(clk), .en(en), .angle(in_angle_y), .sc(scy));
  ezr_sincos u_sc_z (.clk(clk), .en(en), .angle(in_angle_z), .sc(scz));

  // Matrix products, sums and rounding: 6 more stages.
  mat_t mat;

  ezr_matrix #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_matrix (
    .clk (clk),
    .en  (en),
    .scx (scx),
    .scy (scy),
    .scz (scz),
    .mat (mat)
  );

  // Output register plus one-word skid.
  mat_t out_r;
  mat_t skid_r;
  logic out_free;
  logic last_v;

  assign out_free = !out_v_r || !out_stall;
  assign last_v   = v_r[CORE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (en) begin
        v_r <= {v_r[CORE_LAT-2:0], in_valid};
      end
      if (out_free) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= last_v;
        end
      end else if (last_v && en) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_v_r ? skid_r : mat;
    end else if (last_v && en) begin
      skid_r <= mat;
    end
  end

  assign out_valid = out_v_r;
  assign out_r00   = out_r.r00;
  assign out_r01   = out_r.r01;
  assign out_r02   = out_r.r02;
  assign out_r10   = out_r.r10;
  assign out_r11   = out_r.r11;
  assign out_r12   = out_r.r12;
  assign out_r20   = out_r.r20;
  assign out_r21   = out_r.r21;
  assign out_r22   = out_r.r22;

endmodule

// File: bench/euler_zyx_rotation_matrix_core_test.sv
// Self-checking testbench for the ZYX Euler angle to rotation matrix core.
module euler_zyx_rotation_matrix_core_test
  import ezr_pkg::*;
();

  // Random angles stay in the documented range most of the time. Full 16-bit
  // values are mixed in to exercise the modulo-360 wrap and every input bit.
  localparam int N_RANDOM  = 1830;
  localparam int OUT_FRAC  = OUT_FRAC_BITS_DEF;
  localparam int MAX_CYCLE = 200000;
  localparam int LONG_HOLD = 80;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] ax;
    logic signed [ANGLE_W-1:0] ay;
    logic signed [ANGLE_W-1:0] az;
  } angles_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic signed [ANGLE_W-1:0] in_angle_x = '0;
  logic signed [ANGLE_W-1:0] in_angle_y = '0;
  logic signed [ANGLE_W-1:0] in_angle_z = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  entry_t out_r00, out_r01, out_r02, out_r10, out_r11, out_r12;
  entry_t out_r20, out_r21, out_r22;

  euler_zyx_rotation_matrix_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  angles_t pending_words[$];
  mat_t    expected_mats[$];
  int      n_errors = 0;
  int      n_sent = 0;
  int      n_checked = 0;
  int      cycle_count = 0;
  bit      hold_request = 1'b0;   // ask the receiver for one long stall
  bit      pause_request = 1'b0;  // sender drains the pipeline before going on

  // ---------------------------------------------------------------------
  // Predictor: sine/cosine by octant folding plus a truncated Taylor
  // series in Q30, then the closed-form ZYX products rounded from Q60.
  // ---------------------------------------------------------------------
  function automatic longint round_away(longint v, int n);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint clip_unit(longint v);
    if (v < 0) return 0;
    if (v > ONE_Q30) return ONE_Q30;
    return v;
  endfunction

  // b in 0..2880 (0..45 degrees)
  function automatic void series_sincos(input int b, output longint s, output longint c);
    logic [63:0] x, x2, t;
    longint acc;
    x  = (64'(b) * 64'(RAD_K40) + 64'd512) >> 10;
    x2 = (x * x) >> 30;
    t = x;
    acc = longint'(x);
    for (int k = 1; k <= N_SIN_TERMS; k++) begin
      t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc -= longint'(t); else acc += longint'(t);
    end
    s = clip_unit(acc);
    t = 64'(ONE_Q30);
    acc = ONE_Q30;
    for (int k = 1; k <= N_COS_TERMS; k++) begin
      t = ((t * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) acc -= longint'(t); else acc += longint'(t);
    end
    c = clip_unit(acc);
  endfunction

  function automatic void angle_trig(input logic signed [ANGLE_W-1:0] ang,
                                     output longint s, output longint c);
    int a, quad, rem;
    longint s0, c0, tmp;
    a = int'(ang) % UNITS_TURN;
    if (a < 0) a += UNITS_TURN;
    quad = a / UNITS_QUARTER;
    rem  = a % UNITS_QUARTER;
    series_sincos((rem > UNITS_EIGHTH) ? UNITS_QUARTER - rem : rem, s0, c0);
    if (rem > UNITS_EIGHTH) begin
      tmp = s0; s0 = c0; c0 = tmp;
    end
    case (quad)
      0: begin s = s0;  c = c0;  end
      1: begin s = c0;  c = -s0; end
      2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endfunction

  function automatic entry_t to_entry(longint q60);
    longint v, lim;
    v = round_away(q60, 60 - OUT_FRAC);
    lim = 64'sd1 <<< OUT_FRAC;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return entry_t'(v);
  endfunction

  function automatic mat_t zyx_matrix(angles_t w);
    longint sx, cx, sy, cy, sz, cz, czsy, szsy;
    mat_t m;
    angle_trig(w.ax, sx, cx);
    angle_trig(w.ay, sy, cy);
    angle_trig(w.az, sz, cz);
    czsy = round_away(cz * sy, 30);
    szsy = round_away(sz * sy, 30);
    m.r00 = to_entry(cz * cy);
    m.r01 = to_entry(czsy * sx - sz * cx);
    m.r02 = to_entry(czsy * cx + sz * sx);
    m.r10 = to_entry(sz * cy);
    m.r11 = to_entry(szsy * sx + cz * cx);
    m.r12 = to_entry(szsy * cx - cz * sx);
    m.r20 = to_entry(-sy * ONE_Q30);
    m.r21 = to_entry(cy * sx);
    m.r22 = to_entry(cy * cx);
    return m;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return ANGLE_W'($urandom());                        // any 16-bit value
      1: return ANGLE_W'(UNITS_EIGHTH * $urandom_range(0, 16) - UNITS_TURN
                         + $urandom_range(0, 2) - 1);         // near octant edges
      default: return ANGLE_W'($urandom_range(0, 2 * UNITS_TURN) - UNITS_TURN);
    endcase
  endfunction

  // input stall as seen at the rising edge
  logic in_stall_at_edge = 1'b0;
  always @(posedge clk) in_stall_at_edge <= in_stall;

  // ---------------------------------------------------------------------
  // Driver: one word per handshake, random idle gaps between words.
  // A stalled word is held until accepted.
  // ---------------------------------------------------------------------
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_at_edge) begin
        // word taken at the last rising edge
        expected_mats.push_back(zyx_matrix({in_angle_x, in_angle_y, in_angle_z}));
        n_sent++;
        gap_left = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap_left = 0;
      end
      if (!(in_valid && in_stall_at_edge)) begin
        if (gap_left > 0 || pending_words.size() == 0 ||
            (pause_request && expected_mats.size() != 0)) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          if (pause_request) pause_request = 1'b0;
          {in_angle_x, in_angle_y, in_angle_z} <= pending_words.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and receiver stall.
  // ---------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    mat_t want, got;
    cycle_count++;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_r00, out_r01, out_r02, out_r10, out_r11, out_r12,
              out_r20, out_r21, out_r22};
      if (expected_mats.size() == 0) begin
        $error("matrix word with no expectation pending");
        n_errors++;
      end else begin
        want = expected_mats.pop_front();
        n_checked++;
        if (got.r00 !== want.r00) begin
          $error("r00 exp %0d got %0d", want.r00, got.r00); n_errors++;
        end
        if (got.r01 !== want.r01) begin
          $error("r01 exp %0d got %0d", want.r01, got.r01); n_errors++;
        end
        if (got.r02 !== want.r02) begin
          $error("r02 exp %0d got %0d", want.r02, got.r02); n_errors++;
        end
        if (got.r10 !== want.r10) begin
          $error("r10 exp %0d got %0d", want.r10, got.r10); n_errors++;
        end
        if (got.r11 !== want.r11) begin
          $error("r11 exp %0d got %0d", want.r11, got.r11); n_errors++;
        end
        if (got.r12 !== want.r12) begin
          $error("r12 exp %0d got %0d", want.r12, got.r12); n_errors++;
        end
        if (got.r20 !== want.r20) begin
          $error("r20 exp %0d got %0d", want.r20, got.r20); n_errors++;
        end
        if (got.r21 !== want.r21) begin
          $error("r21 exp %0d got %0d", want.r21, got.r21); n_errors++;
        end
        if (got.r22 !== want.r22) begin
          $error("r22 exp %0d got %0d", want.r22, got.r22); n_errors++;
        end
      end
    end
  end

  // Receiver stall changes at the falling edge; random stalls are mixed with
  // stall-free stretches and one long hold-off on request.
  int calm_left = 0;
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 60);
      else stall_left = $urandom_range(0, 3);
      out_stall <= 1'b0;
    end
  end

  // Timeout.
  always @(posedge clk) begin
    if (cycle_count > MAX_CYCLE) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_mats.size());
      $display("euler_zyx_rotation_matrix_core_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed corners, then random words with two pressure events.
  // ---------------------------------------------------------------------
  initial begin
    int limits[$];
    limits = '{0, 1, -1, 2880, 2881, 5760, 11520, 17280, 23040, -23040,
               23039, -2880, -5760, 32767, -32768};
    // the x angle alone at each corner, then mixed words
    foreach (limits[i]) pending_words.push_back({16'(limits[i]), 16'sd0, 16'sd0});
    pending_words.push_back({16'sd0, 16'sd5760, 16'sd0});   // gimbal lock, +90 pitch
    pending_words.push_back({16'sd2880, 16'sd5760, 16'sd2880});
    pending_words.push_back({16'sd0, -16'sd5760, 16'sd0});  // -90 pitch
    pending_words.push_back({16'sd0, 16'sd0, 16'sd23040});
    pending_words.push_back({16'sd0, 16'sd0, -16'sd32768});
    pending_words.push_back({16'sd2880, 16'sd2880, 16'sd2880});
    pending_words.push_back({16'sd32767, 16'sd32767, 16'sd32767});
    pending_words.push_back({-16'sd32768, -16'sd32768, -16'sd32768});
    pending_words.push_back({16'sd11520, 16'sd11520, 16'sd11520});
    pending_words.push_back({-16'sd23040, 16'sd23040, -16'sd1});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 400) hold_request = 1'b1;    // receiver holds; pipeline fills
      if (i == 1000) pause_request = 1'b1;  // sender drains everything first
      pending_words.push_back({rand_angle(), rand_angle(), rand_angle()});
      if (i % 50 == 49) wait (pending_words.size() < 20);
    end

    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_mats.size() == 0);
    repeat (CORE_LAT + 10) @(posedge clk);

    $display("sent %0d angle triples, checked %0d matrices (corners, wraps, octant edges)",
             n_sent, n_checked);
    if (n_errors == 0) begin
      $display("euler_zyx_rotation_matrix_core_test: clean");
    end else begin
      $display("euler_zyx_rotation_matrix_core_test: errors");
    end
    $finish;
  end
endmodule
